// File: rtl/core/csv_delimiter_detector_unit_macros.svh
// Assertion macros for the delimiter detector.
`ifndef CSV_DELIMITER_DETECTOR_UNIT_MACROS_SVH
`define CSV_DELIMITER_DETECTOR_UNIT_MACROS_SVH

// Same-cycle implication.
`define CDD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define CDD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/cdd_pkg.sv
package cdd_pkg;

	localparam int DEF_NUM_CANDIDATES = 7;
	localparam int DEF_COUNT_BITS     = 16;

	// ",|;\t^~ " packed, candidate zero in the low byte
	localparam logic [63:0] CAND_RESET  = 64'h0020_7E5E_093B_7C2C;
	localparam logic [6:0]  LINES_RESET = 7'd100;
	localparam logic [6:0]  LINES_SAT   = 7'd127;
	localparam logic [7:0]  LINE_FEED   = 8'd10;

	typedef enum logic [0:0] {
		REG_CANDIDATE_SET = 1'b0,
		REG_MAX_LINES     = 1'b1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		PH_FIRST   = 3'b001,
		PH_COMPARE = 3'b010,
		PH_DONE    = 3'b100
	} phase_t;

	// controls broadcast to every cell
	typedef struct packed {
		logic active;
		logic line_end;
		logic first;
		logic restart;
	} cell_ctl_t;

	// running pick handed from cell to cell
	typedef struct packed {
		logic [3:0] live;
		logic [2:0] idx;
		logic [7:0] sel;
	} chain_t;

	typedef struct packed {
		logic [7:0] delimiter;
		logic [2:0] delimiter_index;
		logic       fell_back;
	} result_t;

endpackage

// File: rtl/core/cdd_cell.sv
module cdd_cell
	import cdd_pkg::*;
#(
	parameter int          COUNT_BITS = DEF_COUNT_BITS,
	parameter logic [2:0]  IDX        = 3'd0
) (
	input  logic       clk,
	input  logic       arst_n,
	input  cell_ctl_t  ctl,
	input  logic [7:0] data_byte,
	input  logic [7:0] cand,
	input  chain_t     chain_in,
	output chain_t     chain_out
);

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	logic [COUNT_BITS-1:0] cur_q, ref_q, cur_inc;
	logic                  alive_q, alive_eval;

	always_comb begin
		cur_inc = cur_q;
		if (data_byte == cand && cur_q != COUNT_MAX) begin
			cur_inc = cur_q + COUNT_BITS'(1);
		end
		if (ctl.first) begin
			alive_eval = (cur_inc != '0);
		end else begin
			alive_eval = alive_q && (cur_inc == ref_q);
		end
	end

	always_comb begin
		chain_out = chain_in;
		if (alive_eval) begin
			chain_out.live = chain_in.live + 4'd1;
			chain_out.idx  = IDX;
			chain_out.sel  = cand;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q   <= '0;
			ref_q   <= '0;
			alive_q <= 1'b1;
		end else if (ctl.restart) begin
			cur_q   <= '0;
			ref_q   <= '0;
			alive_q <= 1'b1;
		end else if (ctl.active) begin
			if (ctl.line_end) begin
				cur_q   <= '0;
				alive_q <= alive_eval;
				if (ctl.first) begin
					ref_q <= cur_inc;
				end
			end else begin
				cur_q <= cur_inc;
			end
		end
	end

endmodule

// File: rtl/core/cdd_out_buf.sv
module cdd_out_buf
	import cdd_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t res_in,
	input  logic    out_stall,
	output logic    out_valid,
	output result_t res_out,
	output logic    full
);

	logic    head_v_q, skid_v_q, pop;
	result_t head_q, skid_q;

	assign pop       = head_v_q && !out_stall;
	assign out_valid = head_v_q;
	assign res_out   = head_q;
	assign full      = skid_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!head_v_q) begin
			head_v_q <= push;
		end else if (skid_v_q) begin
			if (pop) begin
				skid_v_q <= 1'b0;
			end
		end else if (!pop && push) begin
			skid_v_q <= 1'b1;
		end else if (pop && !push) begin
			head_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (!head_v_q || (pop && !skid_v_q)) begin
			head_q <= res_in;
		end else if (pop) begin
			head_q <= skid_q;
		end
		if (!skid_v_q) begin
			skid_q <= res_in;
		end
	end

endmodule

// File: rtl/core/csv_delimiter_detector_unit.sv
// A result is registered in the output buffer, its head or its skid stage, from the beat that ends its line.
// Throughput: one input beat per cycle while in_stall is low; the cell row evaluates a whole line end in that cycle.
// Input stalls only while two results wait in the output register and its skid stage.
// Reset (arst_n low, asynchronous): counts cleared, all candidates live, first-line phase,
// candidate_set and max_lines back to defaults, output empty. No clearing pass.
module csv_delimiter_detector_unit
	import cdd_pkg::*;
#(
	parameter int NUM_CANDIDATES = DEF_NUM_CANDIDATES,
	parameter int COUNT_BITS     = DEF_COUNT_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [0:0]                  cfg_index,
	input  logic [8*NUM_CANDIDATES-1:0] cfg_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [7:0]                  data_byte,
	input  logic                        end_of_file,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [7:0]                  delimiter,
	output logic [2:0]                  delimiter_index,
	output logic                        fell_back
);

	localparam int SET_W = 8 * NUM_CANDIDATES;

	logic [SET_W-1:0] candidate_set_q;
	logic [6:0]       max_lines_q, lines_q, lines_eval;
	phase_t           phase_q;
	logic             accept, line_end, answer;
	cell_ctl_t        ctl;
	chain_t           chain [0:NUM_CANDIDATES];
	result_t          res_new, res_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			candidate_set_q <= CAND_RESET[SET_W-1:0];
			max_lines_q     <= LINES_RESET;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_CANDIDATE_SET: candidate_set_q <= cfg_data;
				REG_MAX_LINES:     max_lines_q     <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	assign accept   = in_valid && !in_stall;
	assign line_end = (data_byte == LINE_FEED) || end_of_file;

	always_comb begin
		ctl.active   = accept && (phase_q == PH_FIRST || phase_q == PH_COMPARE);
		ctl.first    = (phase_q == PH_FIRST);
		ctl.line_end = line_end;
		ctl.restart  = accept && end_of_file;
	end

	always_comb begin
		lines_eval = lines_q;
		if (!ctl.first && lines_q != LINES_SAT) begin
			lines_eval = lines_q + 7'd1;
		end
	end

	assign chain[0] = '{live: 4'd0, idx: 3'd0, sel: candidate_set_q[7:0]};

	for (genvar i = 0; i < NUM_CANDIDATES; i++) begin : g_cell
		cdd_cell #(
			.COUNT_BITS(COUNT_BITS),
			.IDX       (3'(i))
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.data_byte(data_byte),
			.cand     (candidate_set_q[8*i +: 8]),
			.chain_in (chain[i]),
			.chain_out(chain[i+1])
		);
	end

	assign answer = ctl.active && line_end && (end_of_file
		|| chain[NUM_CANDIDATES].live <= 4'd1 || lines_eval >= max_lines_q);

	always_comb begin
		res_new.delimiter       = chain[NUM_CANDIDATES].sel;
		res_new.delimiter_index = chain[NUM_CANDIDATES].idx;
		res_new.fell_back       = (chain[NUM_CANDIDATES].live == 4'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FIRST;
			lines_q <= '0;
		end else if (ctl.restart) begin
			phase_q <= PH_FIRST;
			lines_q <= '0;
		end else if (ctl.active && line_end) begin
			lines_q <= lines_eval;
			phase_q <= answer ? PH_DONE : PH_COMPARE;
		end
	end

	cdd_out_buf u_out_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (answer),
		.res_in   (res_new),
		.out_stall(out_stall),
		.out_valid(out_valid),
		.res_out  (res_out),
		.full     (in_stall)
	);

	assign delimiter       = res_out.delimiter;
	assign delimiter_index = res_out.delimiter_index;
	assign fell_back       = res_out.fell_back;

endmodule

// File: rtl/core/cdd_checker.sv
`include "csv_delimiter_detector_unit_macros.svh"

module cdd_checker
	import cdd_pkg::*;
#(
	parameter int NUM_CANDIDATES = DEF_NUM_CANDIDATES
) (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        cfg_we,
	input logic [0:0]                  cfg_index,
	input logic [8*NUM_CANDIDATES-1:0] cfg_data,
	input logic                        in_valid,
	input logic                        in_stall,
	input logic [7:0]                  data_byte,
	input logic                        end_of_file,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic [7:0]                  delimiter,
	input logic [2:0]                  delimiter_index,
	input logic                        fell_back
);

	localparam logic [2:0] IDX_MAX = 3'(NUM_CANDIDATES - 1);

	`CDD_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && out_stall,
		out_valid && $stable(delimiter) && $stable(delimiter_index) && $stable(fell_back),
		"stalled result beat changed")

	`CDD_ASSERT_IMP(a_stall_needs_result, clk, arst_n, in_stall, out_valid,
		"input stalled with no result waiting")

	`CDD_ASSERT_IMP(a_index_range, clk, arst_n, out_valid, delimiter_index <= IDX_MAX,
		"delimiter index beyond candidate count")

	`CDD_ASSERT_IMP(a_fallback_zero, clk, arst_n, out_valid && fell_back,
		delimiter_index == 3'd0, "fallback result not candidate zero")

endmodule

bind csv_delimiter_detector_unit cdd_checker #(.NUM_CANDIDATES(NUM_CANDIDATES)) u_cdd_checker (.*);
